>>> rtl/core/bertlv_pkg.sv
// shared types and constants for the ber tlv stream decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bertlv_pkg;

  localparam int MAX_LENGTH_BYTES = 4;

  // result queue sizing: one request can push two results
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;
  localparam logic [4:0] TAG_BOOLEAN     = 5'd1;
  localparam logic [4:0] TAG_INTEGER     = 5'd2;
  localparam logic [4:0] TAG_ENUMERATED  = 5'd10;

  typedef enum logic [1:0] {
    PH_IDENT,
    PH_LEN1,
    PH_LENLONG,
    PH_CONTENT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_CONTENT,
    KIND_INT,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  tag_class;
    logic [4:0]  tag_number;
    logic        constructed;
    logic [31:0] content_length;
    logic [7:0]  content_byte;
    logic [31:0] int_value;
    logic        last_content;
  } result_t;

  typedef struct packed {
    logic [1:0] push_cnt;
    logic       pop;
  } queue_ctl_t;

  typedef struct packed {
    logic room2;
    logic not_empty;
  } queue_sts_t;

endpackage

>>> rtl/core/ber_tlv_stream_decoder_top.sv
// top level of the ber tlv stream decoder: byte parser and result queue
// depends on bertlv_pkg and bertlv_res_queue
`timescale 1ns / 1ps

// Takes one BER byte per cycle while in_stall is low, updating the parser
// state in the same cycle; the results it causes (none, one or two) land
// in a four-entry result queue in the cycle after the request, and leave
// it one per cycle while out_stall is low. With the output side free the
// block sustains one byte per cycle; a byte that ends in two results (a
// header followed by an empty integer value, or a header or content byte
// followed by a truncation error) fills two queue entries. in_stall rises
// when the queue has fewer than two free entries. Tag and length fields of
// every result reflect the parser state after the byte that caused it.
module ber_tlv_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_tag_class,
  output logic [4:0]  out_tag_number,
  output logic        out_constructed,
  output logic [31:0] out_content_length,
  output logic [7:0]  out_content_byte,
  output logic [31:0] out_int_value,
  output logic        out_last_content
);
  import bertlv_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  ident_byte_r, ident_byte_nxt;
  logic [2:0]  len_left_r, len_left_nxt;
  logic [31:0] length_accum_r, length_accum_nxt;
  logic [31:0] content_left_r, content_left_nxt;
  logic [31:0] value_accum_r, value_accum_nxt;
  logic        integer_mode_r, integer_mode_nxt;

  logic        accept;
  logic        len_done;
  logic [6:0]  len_count;
  logic        prim_v;
  kind_t       prim_kind;
  logic [7:0]  prim_byte;
  logic [31:0] prim_ival;
  logic        prim_last;
  logic        sec_v;
  kind_t       sec_kind;
  logic        sec_last;
  result_t     prim_res;
  result_t     sec_res;
  result_t     head;
  queue_ctl_t  q_ctl;
  queue_sts_t  q_sts;

  assign accept    = in_valid & ~in_stall;
  assign len_count = in_data_byte[6:0];

  always_comb begin
    phase_nxt        = phase_r;
    ident_byte_nxt   = ident_byte_r;
    len_left_nxt     = len_left_r;
    length_accum_nxt = length_accum_r;
    content_left_nxt = content_left_r;
    value_accum_nxt  = value_accum_r;
    integer_mode_nxt = integer_mode_r;
    len_done  = 1'b0;
    prim_v    = 1'b0;
    prim_kind = KIND_HEADER;
    prim_byte = 8'd0;
    prim_ival = 32'd0;
    prim_last = 1'b0;
    sec_v     = 1'b0;
    sec_kind  = KIND_ERROR;
    sec_last  = 1'b0;

    if (accept) begin
      case (phase_r)
        PH_LEN1: begin
          if (!in_data_byte[7]) begin
            length_accum_nxt = {24'd0, in_data_byte};
            len_done         = 1'b1;
          end else begin
            length_accum_nxt = 32'd0;
            if (len_count == 7'd0) begin
              // indefinite form reads as length zero
              len_done = 1'b1;
            end else if (len_count > 7'(MAX_LENGTH_BYTES)) begin
              prim_v    = 1'b1;
              prim_kind = KIND_ERROR;
              phase_nxt = PH_IDENT;
            end else begin
              len_left_nxt = len_count[2:0];
              phase_nxt    = PH_LENLONG;
            end
          end
        end
        PH_LENLONG: begin
          length_accum_nxt = {length_accum_r[23:0], in_data_byte};
          len_left_nxt     = len_left_r - 3'd1;
          len_done         = (len_left_nxt == 3'd0);
        end
        PH_CONTENT: begin
          content_left_nxt = content_left_r - 32'd1;
          if (integer_mode_r) begin
            value_accum_nxt = {value_accum_r[23:0], in_data_byte};
            if (content_left_nxt == 32'd0) begin
              prim_v    = 1'b1;
              prim_kind = KIND_INT;
              prim_ival = value_accum_nxt;
              prim_last = 1'b1;
            end
          end else begin
            prim_v    = 1'b1;
            prim_kind = KIND_CONTENT;
            prim_byte = in_data_byte;
            prim_last = (content_left_nxt == 32'd0);
          end
          if (content_left_nxt == 32'd0) begin
            integer_mode_nxt = 1'b0;
            phase_nxt        = PH_IDENT;
          end
        end
        default: begin
          ident_byte_nxt   = in_data_byte;
          length_accum_nxt = 32'd0;
          len_left_nxt     = 3'd0;
          content_left_nxt = 32'd0;
          value_accum_nxt  = 32'd0;
          integer_mode_nxt = 1'b0;
          phase_nxt        = PH_LEN1;
        end
      endcase

      // length complete: header out, then pick contents handling
      if (len_done) begin
        prim_v          = 1'b1;
        prim_kind       = KIND_HEADER;
        len_left_nxt    = 3'd0;
        value_accum_nxt = 32'd0;
        if (ident_byte_r[5]) begin
          integer_mode_nxt = 1'b0;
          phase_nxt        = PH_IDENT;
        end else begin
          integer_mode_nxt = (ident_byte_r[7:6] == CLASS_UNIVERSAL) &&
                             (ident_byte_r[4:0] == TAG_BOOLEAN ||
                              ident_byte_r[4:0] == TAG_INTEGER ||
                              ident_byte_r[4:0] == TAG_ENUMERATED);
          if (length_accum_nxt == 32'd0) begin
            // empty integer still reports a zero value
            if (integer_mode_nxt) begin
              sec_v    = 1'b1;
              sec_kind = KIND_INT;
              sec_last = 1'b1;
            end
            integer_mode_nxt = 1'b0;
            phase_nxt        = PH_IDENT;
          end else begin
            content_left_nxt = length_accum_nxt;
            phase_nxt        = PH_CONTENT;
          end
        end
      end

      // stream ends inside an element
      if (in_stream_end && phase_nxt != PH_IDENT) begin
        sec_v            = 1'b1;
        sec_kind         = KIND_ERROR;
        sec_last         = 1'b0;
        phase_nxt        = PH_IDENT;
        len_left_nxt     = 3'd0;
        content_left_nxt = 32'd0;
        value_accum_nxt  = 32'd0;
        integer_mode_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDENT;
      ident_byte_r   <= 8'd0;
      len_left_r     <= 3'd0;
      length_accum_r <= 32'd0;
      content_left_r <= 32'd0;
      value_accum_r  <= 32'd0;
      integer_mode_r <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      ident_byte_r   <= ident_byte_nxt;
      len_left_r     <= len_left_nxt;
      length_accum_r <= length_accum_nxt;
      content_left_r <= content_left_nxt;
      value_accum_r  <= value_accum_nxt;
      integer_mode_r <= integer_mode_nxt;
    end
  end

  // all results of one request share the post-update tag and length
  always_comb begin
    prim_res.kind           = prim_kind;
    prim_res.tag_class      = ident_byte_nxt[7:6];
    prim_res.tag_number     = ident_byte_nxt[4:0];
    prim_res.constructed    = ident_byte_nxt[5];
    prim_res.content_length = length_accum_nxt;
    prim_res.content_byte   = prim_byte;
    prim_res.int_value      = prim_ival;
    prim_res.last_content   = prim_last;

    sec_res              = prim_res;
    sec_res.kind         = sec_kind;
    sec_res.content_byte = 8'd0;
    sec_res.int_value    = 32'd0;
    sec_res.last_content = sec_last;
  end

  assign q_ctl.push_cnt = {1'b0, prim_v} + {1'b0, sec_v};
  assign q_ctl.pop      = out_valid & ~out_stall;

  bertlv_res_queue u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .wr0   (prim_v ? prim_res : sec_res),
    .wr1   (sec_res),
    .sts   (q_sts),
    .head  (head)
  );

  assign in_stall           = ~q_sts.room2;
  assign out_valid          = q_sts.not_empty;
  assign out_kind           = head.kind;
  assign out_tag_class      = head.tag_class;
  assign out_tag_number     = head.tag_number;
  assign out_constructed    = head.constructed;
  assign out_content_length = head.content_length;
  assign out_content_byte   = head.content_byte;
  assign out_int_value      = head.int_value;
  assign out_last_content   = head.last_content;

`ifndef SYNTHESIS
  a_ident_to_len1: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_IDENT && !in_stream_end |=> phase_r == PH_LEN1)
    else $error("identifier byte did not move parser to length phase");

  a_len_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_LENLONG |-> len_left_r == 3'd0)
    else $error("length byte count live outside long length phase");

  a_int_mode_content: assert property (@(posedge clk) disable iff (!rst_n)
    integer_mode_r |-> phase_r == PH_CONTENT)
    else $error("integer mode set outside content phase");

  a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CONTENT |-> content_left_r != 32'd0)
    else $error("content phase with nothing left");
`endif

endmodule

>>> rtl/core/bertlv_res_queue.sv
// small result queue: takes up to two results per cycle, hands out one
// depends on bertlv_pkg
`timescale 1ns / 1ps

module bertlv_res_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bertlv_pkg::queue_ctl_t ctl,
  input  bertlv_pkg::result_t    wr0,
  input  bertlv_pkg::result_t    wr1,
  output bertlv_pkg::queue_sts_t sts,
  output bertlv_pkg::result_t    head
);
  import bertlv_pkg::*;

  result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(ctl.push_cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(ctl.pop);
    count_nxt  = count_r + QCNT_W'(ctl.push_cnt) - QCNT_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr0;
    end
    if (ctl.push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= wr1;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign sts.not_empty = (count_r != '0);
  assign sts.room2     = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule
